>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> hdl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Widths, constants, sequencer states and divider request types.
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int TS_W       = 64;
    localparam int SUM_W      = 64;
    localparam int CNT_W      = 32;
    localparam int TOL_W      = 7;
    localparam int SETTLE_W   = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam int PROD_W     = SUM_W + TOL_W;
    localparam int STEP_W     = 6;

    localparam logic [CNT_W-1:0]    TICK_PERIOD_US = 32'd1000;
    localparam logic [CNT_W-1:0]    PCT_DIV        = 32'd100;
    localparam logic [TOL_W-1:0]    TOL_RESET      = 7'd5;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET   = 10'd10;

    // divider step counts, two quotient bits per step
    localparam logic [STEP_W-1:0] STEPS_FULL = 6'd32;  // 64-bit dividend
    localparam logic [STEP_W-1:0] STEPS_ERR  = 6'd20;  // dividend below 2^40
    localparam logic [STEP_W-1:0] STEPS_LO   = 6'd7;   // dividend below 2^14
    localparam int ERR_ALIGN = SUM_W - 2 * 20;
    localparam int LO_ALIGN  = SUM_W - 2 * 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_MEAN,
        ST_ERR_GO,
        ST_ERR_WAIT,
        ST_HI_WAIT,
        ST_LO_GO,
        ST_LO_WAIT,
        ST_BOUND,
        ST_DECIDE,
        ST_ACCUM,
        ST_FLAG,
        ST_OUT_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [CNT_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quo;
        logic [CNT_W-1:0] rem;
    } t_div_rsp;

endpackage

>>> hdl/tsc_div.sv
// ----------------------------------------------------------------------------
// tsc_div
// Shared restoring divider, 64-bit dividend by 32-bit divisor, two bits a
// cycle. Dividend comes in left-aligned to the number of steps asked for.
// ----------------------------------------------------------------------------
module tsc_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tsc_pkg::t_div_req i_req,
    output tsc_pkg::t_div_rsp o_rsp
);
    import tsc_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_left;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dsr;
    logic [SUM_W-1:0]  n_quo;
    logic [CNT_W-1:0]  n_rem;
    logic [CNT_W:0]    w_sh;

    // two dependent shift/compare/subtract steps
    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        w_sh  = '0;
        for (int k = 0; k < 2; k++) begin
            w_sh  = {n_rem, n_quo[SUM_W-1]};
            n_quo = {n_quo[SUM_W-2:0], 1'b0};
            if (w_sh >= {1'b0, r_dsr}) begin
                n_rem    = CNT_W'(w_sh - {1'b0, r_dsr});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = w_sh[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_left <= i_req.steps;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dsr  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo  <= n_quo;
                r_rem  <= n_rem;
                r_left <= r_left - 1'b1;
                if (r_left == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

>>> hdl/tsc_rate_calibrator_core.sv
// ----------------------------------------------------------------------------
// tsc_rate_calibrator_core
// Running cycles-per-microsecond average with outlier rejection.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) takes one timestamp word per timer
//   tick. Output channel (o_valid / i_ready) returns one word per tick:
//   the mean of accepted samples, the sticky calibrated flag and whether
//   this tick's sample went into the average.
//   Config channel (i_cfg_valid / o_cfg_ready) is always ready; index 0 is
//   tolerance_percent (data[6:0]), index 1 is settle_count (data[9:0]).
//   Write it only while no tick is in flight.
// Timing:
//   One tick at a time. All divides run on one shared divider that makes
//   two quotient bits per cycle. A tick in the first phase (sum still zero)
//   takes two divides; a normal tick takes six divides plus the
//   multiply/compare steps. o_ready is low while a tick is in work.
// Reset:
//   Synchronous, active low. Clears sum, count, previous timestamp and
//   the flag; tolerance returns to 5 percent, settle count to 10.
// Stall:
//   The result holds on the output until taken; the next tick is not
//   accepted before then.
// ----------------------------------------------------------------------------
module tsc_rate_calibrator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [tsc_pkg::TS_W-1:0]       i_timestamp,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [tsc_pkg::SUM_W-1:0]      o_cycles_per_us,
    output logic                           o_calibrated,
    output logic                           o_sample_accepted,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tsc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tsc_pkg::*;

    // sequencer
    t_state r_state;
    t_state n_state;

    // configuration
    logic [TOL_W-1:0]    r_tol;
    logic [SETTLE_W-1:0] r_settle;

    // architectural state
    logic [TS_W-1:0]  r_prev;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_count;
    logic             r_flag;

    // per-tick working registers
    logic [SUM_W-1:0] r_sample;
    logic [SUM_W-1:0] r_mean;
    logic [CNT_W-1:0] r_rem;    // sum % count, later mean % 100
    logic [TOL_W-1:0] r_err;    // (sum % count) * tol / count
    logic [SUM_W-1:0] r_hi;     // mean / 100
    logic [TOL_W-1:0] r_lo;     // low part of the bound
    logic [SUM_W-1:0] r_bound;
    logic [SUM_W-1:0] r_dev;
    logic             r_acc;
    logic             r_chk;    // sum was nonzero at tick start
    logic [SUM_W-1:0] r_out_mean;

    // shared divider
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    // datapath nets
    logic [CNT_W-1:0]  w_cnt_div;
    logic [SUM_W-1:0]  w_mul_a;
    logic [PROD_W-1:0] w_prod;
    logic [SUM_W-1:0]  w_lo_num;
    logic [SUM_W:0]    w_bsum;
    logic              w_bsat;
    logic [SUM_W:0]    w_sum_add;

    tsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // a count of zero divides as one
    assign w_cnt_div = (r_count == '0) ? CNT_W'(1) : r_count;

    // one multiplier by the tolerance, shared by three steps
    assign w_mul_a  = (r_state == ST_BOUND) ? r_hi : SUM_W'(r_rem);
    assign w_prod   = PROD_W'(w_mul_a) * PROD_W'(r_tol);
    assign w_lo_num = w_prod[SUM_W-1:0] + SUM_W'(r_err);

    // bound = hi*tol + lo, saturating
    assign w_bsum = {1'b0, w_prod[SUM_W-1:0]} + (SUM_W+1)'(r_lo);
    assign w_bsat = (|w_prod[PROD_W-1:SUM_W]) | w_bsum[SUM_W];

    assign w_sum_add = {1'b0, r_sum} + {1'b0, r_sample};

    // next state and divider requests
    always_comb begin
        n_state   = r_state;
        w_div_req = '0;
        o_ready   = 1'b0;
        o_valid   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = i_timestamp - r_prev;
                    w_div_req.divisor  = TICK_PERIOD_US;
                    w_div_req.steps    = STEPS_FULL;
                    n_state            = ST_SAMPLE;
                end
            end
            ST_SAMPLE: begin
                if (w_div_rsp.done) begin
                    if (r_sum == '0) begin
                        n_state = ST_ACCUM;
                    end else begin
                        w_div_req.start    = 1'b1;
                        w_div_req.dividend = r_sum;
                        w_div_req.divisor  = w_cnt_div;
                        w_div_req.steps    = STEPS_FULL;
                        n_state            = ST_MEAN;
                    end
                end
            end
            ST_MEAN: begin
                if (w_div_rsp.done) begin
                    n_state = ST_ERR_GO;
                end
            end
            ST_ERR_GO: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = w_prod[SUM_W-1:0] << ERR_ALIGN;
                w_div_req.divisor  = w_cnt_div;
                w_div_req.steps    = STEPS_ERR;
                n_state            = ST_ERR_WAIT;
            end
            ST_ERR_WAIT: begin
                if (w_div_rsp.done) begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = r_mean;
                    w_div_req.divisor  = PCT_DIV;
                    w_div_req.steps    = STEPS_FULL;
                    n_state            = ST_HI_WAIT;
                end
            end
            ST_HI_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = ST_LO_GO;
                end
            end
            ST_LO_GO: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = w_lo_num << LO_ALIGN;
                w_div_req.divisor  = PCT_DIV;
                w_div_req.steps    = STEPS_LO;
                n_state            = ST_LO_WAIT;
            end
            ST_LO_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = ST_BOUND;
                end
            end
            ST_BOUND: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_state = ST_ACCUM;
            end
            ST_ACCUM: begin
                n_state = ST_FLAG;
            end
            ST_FLAG: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = r_sum;
                w_div_req.divisor  = w_cnt_div;
                w_div_req.steps    = STEPS_FULL;
                n_state            = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= TOL_RESET;
            r_settle <= SETTLE_RESET;
            r_prev   <= '0;
            r_sum    <= '0;
            r_count  <= '0;
            r_flag   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TOLERANCE: r_tol    <= i_cfg_data[TOL_W-1:0];
                    CFG_SETTLE:    r_settle <= i_cfg_data[SETTLE_W-1:0];
                    default:       ;
                endcase
            end
            if (r_state == ST_IDLE && i_valid) begin
                r_prev <= i_timestamp;
            end
            if (r_state == ST_ACCUM && r_acc) begin
                r_sum <= w_sum_add[SUM_W] ? '1 : w_sum_add[SUM_W-1:0];
                if (r_count != '1) begin
                    r_count <= r_count + 1'b1;
                end
            end
            // flag is only examined once the sum was nonzero at tick start
            if (r_state == ST_FLAG && r_chk && !r_flag
                    && r_count >= CNT_W'(r_settle)) begin
                r_flag <= 1'b1;
            end
        end
    end

    // per-tick working registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_SAMPLE: begin
                if (w_div_rsp.done) begin
                    r_sample <= w_div_rsp.quo;
                    r_chk    <= (r_sum != '0);
                    r_acc    <= (r_sum == '0);
                end
            end
            ST_MEAN: begin
                if (w_div_rsp.done) begin
                    r_mean <= w_div_rsp.quo;
                    r_rem  <= w_div_rsp.rem;
                end
            end
            ST_ERR_WAIT: begin
                if (w_div_rsp.done) begin
                    r_err <= w_div_rsp.quo[TOL_W-1:0];
                end
            end
            ST_HI_WAIT: begin
                if (w_div_rsp.done) begin
                    r_hi  <= w_div_rsp.quo;
                    r_rem <= w_div_rsp.rem;
                end
            end
            ST_LO_WAIT: begin
                if (w_div_rsp.done) begin
                    r_lo <= w_div_rsp.quo[TOL_W-1:0];
                end
            end
            ST_BOUND: begin
                r_bound <= w_bsat ? '1 : w_bsum[SUM_W-1:0];
                r_dev   <= (r_mean > r_sample) ? (r_mean - r_sample)
                                               : (r_sample - r_mean);
            end
            ST_DECIDE: begin
                r_acc <= (r_dev < r_bound);
            end
            ST_OUT_WAIT: begin
                if (w_div_rsp.done) begin
                    r_out_mean <= w_div_rsp.quo;
                end
            end
            default: ;
        endcase
    end

    assign o_cfg_ready       = 1'b1;
    assign o_cycles_per_us   = r_out_mean;
    assign o_calibrated      = r_flag;
    assign o_sample_accepted = r_acc;

endmodule

>>> hdl/tsc_chk.sv
// ----------------------------------------------------------------------------
// tsc_chk
// Port-level checks for the calibrator core, bound to the core module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsc_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_calibrated
);

    // one tick in flight: never ready while a result word waits
    `CHK_IMPLY(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready)

    // a taken input word starts work at once
    `CHK_NEXT(a_busy_after_in, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

    // a taken result word is gone the next cycle
    `CHK_NEXT(a_out_once, i_clk, i_rst_n, o_valid && i_ready, !o_valid)

    // calibrated flag is sticky until reset
    `CHK_NEXT(a_flag_sticky, i_clk, i_rst_n, o_calibrated, o_calibrated)

endmodule

bind tsc_rate_calibrator_core tsc_chk u_tsc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_calibrated (o_calibrated)
);
